@@ design/assert_macros.svh @@
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every rising edge outside reset.
`define OLSS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication, checked on every rising edge outside reset.
`define OLSS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ design/olss_pkg.sv @@
`default_nettype none

package olss_pkg;

  localparam int WORD_W  = 32;
  localparam int INDEX_W = 4;
  localparam int COUNT_W = 5;
  localparam int CMD_W   = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_READ   = 3'd3,
    CMD_SEARCH = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // What a cell loads on the next edge.
  typedef enum logic [1:0] {
    ACT_HOLD  = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_LEFT  = 2'd2,
    ACT_RIGHT = 2'd3
  } act_t;

  typedef struct packed {
    logic [WORD_W-1:0] data;
    logic              match;
  } cell_out_t;

endpackage

`default_nettype wire

@@ design/olss_cell.sv @@
`default_nettype none

module olss_cell (
  input  wire                        clk,
  input  olss_pkg::act_t             act,
  input  wire  [olss_pkg::WORD_W-1:0] word,
  input  wire  [olss_pkg::WORD_W-1:0] left_data,
  input  wire  [olss_pkg::WORD_W-1:0] right_data,
  output olss_pkg::cell_out_t        cell_q
);
  import olss_pkg::*;

  logic [WORD_W-1:0] data_r;
  logic [WORD_W-1:0] data_nxt;

  always_comb begin
    unique case (act)
      ACT_LOAD:  data_nxt = word;
      ACT_LEFT:  data_nxt = left_data;
      ACT_RIGHT: data_nxt = right_data;
      default:   data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign cell_q.data  = data_r;
  assign cell_q.match = (data_r == word);

endmodule

`default_nettype wire

@@ design/ordered_list_shift_store.sv @@
// A result strobes on out_valid in the cycle after start is taken.
// Throughput: one command per cycle; busy stays low, and every cell moves at the same edge.
// The receiver cannot stall: each result word is shown for exactly one cycle.
// Reset (rst_n low, synchronous) empties the list and drops any pending result;
// entry contents are unknown until written, and only written entries are read.
`default_nettype none

module ordered_list_shift_store #(
  parameter int DEPTH = 16
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               start,
  output logic                              busy,
  input  wire  [olss_pkg::CMD_W-1:0]        in_command,
  input  wire  [olss_pkg::INDEX_W-1:0]      in_index,
  input  wire  signed [olss_pkg::WORD_W-1:0] in_value,
  output logic                              out_valid,
  output logic [1:0]                        out_status,
  output logic signed [olss_pkg::WORD_W-1:0] out_read_value,
  output logic [olss_pkg::INDEX_W-1:0]      out_found_index,
  output logic [olss_pkg::COUNT_W-1:0]      out_item_count
);
  import olss_pkg::*;

  // Count width, and a compare width wide enough for both count and index.
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > COUNT_W) ? CW : COUNT_W;

  logic [CW-1:0]       cnt_r;
  logic                out_valid_r;
  status_t             status_r;
  logic [WORD_W-1:0]   read_r;
  logic [INDEX_W-1:0]  found_r;
  logic [CMPW-1:0]     cnt_out_r;

  logic                accept;
  cmd_t                cmd;
  logic [CMPW-1:0]     cnt_ext;
  logic [CMPW-1:0]     pos_ext;
  logic                full;
  logic [CMPW-1:0]     cnt_nxt;
  status_t             status_nxt;
  logic [WORD_W-1:0]   read_nxt;
  logic [INDEX_W-1:0]  found_nxt;
  logic                hit;
  logic [INDEX_W-1:0]  hit_idx;
  logic [WORD_W-1:0]   rd_sel;

  act_t                act [DEPTH];
  cell_out_t           cell_q [DEPTH];

  assign busy    = 1'b0;
  assign accept  = start & ~busy;
  assign cmd     = cmd_t'(in_command);
  assign cnt_ext = CMPW'(cnt_r);
  assign pos_ext = CMPW'(in_index);
  assign full    = (cnt_ext == CMPW'(DEPTH));

  // The row of cells: each word sits in one cell and can take its
  // neighbor's word on the next edge, so every word of a shift moves at the same edge.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WORD_W-1:0] left_w;
    logic [WORD_W-1:0] right_w;

    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_q[g-1].data;
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_q[g+1].data;
    end

    olss_cell u_cell (
      .clk        (clk),
      .act        (act[g]),
      .word       (in_value),
      .left_data  (left_w),
      .right_data (right_w),
      .cell_q     (cell_q[g])
    );
  end

  // Pick the addressed word and the first live match; each cell compares
  // against the search word on its own.
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    rd_sel  = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (cell_q[i].match && (CMPW'(i) < cnt_ext)) begin
        hit     = 1'b1;
        hit_idx = INDEX_W'(i);
      end
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (pos_ext == CMPW'(i)) begin
        rd_sel = rd_sel | cell_q[i].data;
      end
    end
  end

  // Decode the command into one action per cell plus the result word.
  always_comb begin
    status_nxt = ST_OK;
    read_nxt   = '0;
    found_nxt  = '0;
    cnt_nxt    = cnt_ext;
    for (int i = 0; i < DEPTH; i++) begin
      act[i] = ACT_HOLD;
    end
    if (accept) begin
      unique case (cmd)
        CMD_APPEND: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            // write at the tail
            for (int i = 0; i < DEPTH; i++) begin
              if (CMPW'(i) == cnt_ext) act[i] = ACT_LOAD;
            end
            cnt_nxt = cnt_ext + CMPW'(1);
          end
        end
        CMD_INSERT: begin
          if (pos_ext > cnt_ext) begin
            status_nxt = ST_BAD_INDEX;
          end else if (full) begin
            status_nxt = ST_FULL;
          end else begin
            // open a slot at the index, advance the tail up by one
            for (int i = 0; i < DEPTH; i++) begin
              if (CMPW'(i) == pos_ext) begin
                act[i] = ACT_LOAD;
              end else if ((CMPW'(i) > pos_ext) && (CMPW'(i) <= cnt_ext)) begin
                act[i] = ACT_LEFT;
              end
            end
            cnt_nxt = cnt_ext + CMPW'(1);
          end
        end
        CMD_REMOVE: begin
          if (pos_ext >= cnt_ext) begin
            status_nxt = ST_BAD_INDEX;
          end else begin
            // close the gap: later words drop down by one
            for (int i = 0; i < DEPTH; i++) begin
              if ((CMPW'(i) >= pos_ext) && (CMPW'(i + 1) < cnt_ext)) begin
                act[i] = ACT_RIGHT;
              end
            end
            cnt_nxt = cnt_ext - CMPW'(1);
          end
        end
        CMD_READ: begin
          if (pos_ext >= cnt_ext) begin
            status_nxt = ST_BAD_INDEX;
          end else begin
            read_nxt = rd_sel;
          end
        end
        CMD_SEARCH: begin
          if (hit) begin
            found_nxt = hit_idx;
          end else begin
            status_nxt = ST_NOT_FOUND;
          end
        end
        default: begin
          // unknown command: leave the list alone, report ok
        end
      endcase
    end
  end

  // Control state: fill count and result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt[CW-1:0];
      out_valid_r <= accept;
    end
  end

  // Result word; holds no meaning while the strobe is low.
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r  <= status_nxt;
      read_r    <= read_nxt;
      found_r   <= found_nxt;
      cnt_out_r <= cnt_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_read_value  = read_r;
  assign out_found_index = found_r;
  assign out_item_count  = cnt_out_r[COUNT_W-1:0];

endmodule

`default_nettype wire

@@ design/olss_checker.sv @@
`default_nettype none
`include "assert_macros.svh"

module olss_checker #(
  parameter int DEPTH = 16
) (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          start,
  input wire                          busy,
  input wire                          out_valid,
  input wire [1:0]                    out_status,
  input wire [olss_pkg::WORD_W-1:0]   out_read_value,
  input wire [olss_pkg::INDEX_W-1:0]  out_found_index,
  input wire [olss_pkg::COUNT_W-1:0]  out_item_count
);
  import olss_pkg::*;

  // One result per accepted command, strobed in the cycle after it is accepted.
  `OLSS_ASSERT(a_one_result, clk, rst_n, 1'b1 |=> (out_valid == ($past(rst_n) && $past(start && !busy))), "result strobe does not follow accept")

  `OLSS_ASSERT_IMPL(a_count_cap, clk, rst_n, out_valid, (32'(out_item_count) <= DEPTH) || (DEPTH > 31), "count above capacity")

  `OLSS_ASSERT_IMPL(a_miss_zero, clk, rst_n, out_valid && (out_status == ST_NOT_FOUND), (out_found_index == '0) && (out_read_value == '0), "miss carries data")

  // A refused command leaves the count unchanged.
  `OLSS_ASSERT_IMPL(a_err_hold, clk, rst_n, out_valid && $past(out_valid) && (out_status != ST_OK), out_item_count == $past(out_item_count), "count moved on error")

endmodule

bind ordered_list_shift_store olss_checker #(.DEPTH(DEPTH)) u_olss_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_read_value  (out_read_value),
  .out_found_index (out_found_index),
  .out_item_count  (out_item_count)
);

`default_nettype wire
